// File: rtl/lrsp_pkg.sv
package lrsp_pkg;

  localparam int unsigned FifoDepthDefault = 2;

  localparam logic [7:0] RecData    = 8'h01;
  localparam logic [7:0] RecStartA  = 8'h02;
  localparam logic [7:0] RecStartB  = 8'h03;
  localparam logic [7:0] RecComment = 8'h05;
  localparam logic [7:0] AddrLen    = 8'd2;
  localparam logic [7:0] WrapMax    = 8'd2;
  // lengths up to WrapMax mean length plus 256, minus the two address bytes
  localparam logic [8:0] WrapAdjust = 9'd254;

  typedef enum logic [2:0] {
    KindData    = 3'd0,
    KindHeader  = 3'd1,
    KindEmpty   = 3'd2,
    KindStart   = 3'd3,
    KindEof     = 3'd4,
    KindBadLen  = 3'd5,
    KindUnknown = 3'd6
  } kind_e;

  typedef enum logic [2:0] {
    PhType = 3'd0,
    PhLen  = 3'd1,
    PhAlo  = 3'd2,
    PhAhi  = 3'd3,
    PhData = 3'd4,
    PhHdr  = 3'd5,
    PhSkip = 3'd6
  } phase_e;

  typedef struct packed {
    kind_e       kind;
    logic [16:0] address;
    logic [7:0]  value;
    logic        last;
  } result_t;

endpackage

// File: rtl/lrsp_front.sv
module lrsp_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  logic [7:0]          byte_value_i,
  input  logic                end_of_stream_i,
  output logic                push_o,
  output lrsp_pkg::result_t   result_o
);

  lrsp_pkg::phase_e phase_q, phase_d;
  logic [7:0]  record_kind_q, record_kind_d;
  logic [8:0]  remaining_q, remaining_d;
  logic [8:0]  index_q, index_d;
  logic [7:0]  addr_lo_q, addr_lo_d;
  logic [15:0] base_q, base_d;
  logic        data_seen_q, data_seen_d;
  logic        terminated_q, terminated_d;
  logic        halted_q, halted_d;

  logic        is_start_type;
  logic [8:0]  byte_ext;

  assign is_start_type = (record_kind_q == lrsp_pkg::RecStartA) ||
                         (record_kind_q == lrsp_pkg::RecStartB);
  assign byte_ext = {1'b0, byte_value_i};

  always_comb begin
    phase_d       = phase_q;
    record_kind_d = record_kind_q;
    remaining_d   = remaining_q;
    index_d       = index_q;
    addr_lo_d     = addr_lo_q;
    base_d        = base_q;
    data_seen_d   = data_seen_q;
    terminated_d  = terminated_q;
    halted_d      = halted_q;
    push_o        = 1'b0;
    result_o      = '0;

    if (fire_i && !halted_q && !terminated_q) begin
      if (end_of_stream_i) begin
        halted_d      = 1'b1;
        push_o        = 1'b1;
        result_o.kind = lrsp_pkg::KindEof;
        result_o.last = 1'b1;
      end else begin
        unique case (phase_q)
          lrsp_pkg::PhType: begin
            record_kind_d = byte_value_i;
            phase_d       = lrsp_pkg::PhLen;
          end
          lrsp_pkg::PhLen: begin
            index_d = '0;
            if (record_kind_q == lrsp_pkg::RecData) begin
              remaining_d = (byte_value_i <= lrsp_pkg::WrapMax) ?
                            byte_ext + lrsp_pkg::WrapAdjust :
                            byte_ext - {1'b0, lrsp_pkg::AddrLen};
              phase_d     = lrsp_pkg::PhAlo;
            end else if (is_start_type) begin
              if (byte_value_i == lrsp_pkg::AddrLen) begin
                phase_d = lrsp_pkg::PhAlo;
              end else if (byte_value_i == 8'd0) begin
                halted_d      = 1'b1;
                phase_d       = lrsp_pkg::PhType;
                push_o        = 1'b1;
                result_o.kind = lrsp_pkg::KindBadLen;
                result_o.last = 1'b1;
              end else begin
                remaining_d = byte_ext;
                phase_d     = lrsp_pkg::PhSkip;
              end
            end else if (record_kind_q == lrsp_pkg::RecComment && !data_seen_q) begin
              if (byte_value_i == 8'd0) begin
                phase_d       = lrsp_pkg::PhType;
                push_o        = 1'b1;
                result_o.kind = lrsp_pkg::KindEmpty;
                result_o.last = 1'b1;
              end else begin
                remaining_d = byte_ext;
                phase_d     = lrsp_pkg::PhHdr;
              end
            end else if (byte_value_i == 8'd0) begin
              phase_d = lrsp_pkg::PhType;
              if (record_kind_q != lrsp_pkg::RecComment) begin
                push_o         = 1'b1;
                result_o.kind  = lrsp_pkg::KindUnknown;
                result_o.value = record_kind_q;
                result_o.last  = 1'b1;
              end
            end else begin
              remaining_d = byte_ext;
              phase_d     = lrsp_pkg::PhSkip;
            end
          end
          lrsp_pkg::PhAlo: begin
            addr_lo_d = byte_value_i;
            phase_d   = lrsp_pkg::PhAhi;
          end
          lrsp_pkg::PhAhi: begin
            base_d = {byte_value_i, addr_lo_q};
            if (record_kind_q == lrsp_pkg::RecData) begin
              phase_d = lrsp_pkg::PhData;
            end else begin
              terminated_d     = 1'b1;
              phase_d          = lrsp_pkg::PhType;
              push_o           = 1'b1;
              result_o.kind    = lrsp_pkg::KindStart;
              result_o.address = {1'b0, byte_value_i, addr_lo_q};
              result_o.last    = 1'b1;
            end
          end
          lrsp_pkg::PhData: begin
            index_d          = index_q + 9'd1;
            remaining_d      = remaining_q - 9'd1;
            push_o           = 1'b1;
            result_o.kind    = lrsp_pkg::KindData;
            result_o.address = {1'b0, base_q} + {8'd0, index_q};
            result_o.value   = byte_value_i;
            result_o.last    = (remaining_d == 9'd0);
            if (remaining_d == 9'd0) begin
              data_seen_d = 1'b1;
              phase_d     = lrsp_pkg::PhType;
            end
          end
          lrsp_pkg::PhHdr: begin
            index_d          = index_q + 9'd1;
            remaining_d      = remaining_q - 9'd1;
            push_o           = 1'b1;
            result_o.kind    = lrsp_pkg::KindHeader;
            result_o.address = {8'd0, index_q};
            result_o.value   = byte_value_i;
            result_o.last    = (remaining_d == 9'd0);
            if (remaining_d == 9'd0) begin
              phase_d = lrsp_pkg::PhType;
            end
          end
          lrsp_pkg::PhSkip: begin
            index_d     = index_q + 9'd1;
            remaining_d = remaining_q - 9'd1;
            if (remaining_d == 9'd0) begin
              phase_d = lrsp_pkg::PhType;
              if (is_start_type) begin
                halted_d       = 1'b1;
                push_o         = 1'b1;
                result_o.kind  = lrsp_pkg::KindBadLen;
                result_o.value = index_d[7:0];
                result_o.last  = 1'b1;
              end else if (record_kind_q != lrsp_pkg::RecComment) begin
                push_o         = 1'b1;
                result_o.kind  = lrsp_pkg::KindUnknown;
                result_o.value = record_kind_q;
                result_o.last  = 1'b1;
              end
            end
          end
          default: begin
            phase_d = lrsp_pkg::PhType;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= lrsp_pkg::PhType;
      record_kind_q <= '0;
      remaining_q   <= '0;
      index_q       <= '0;
      addr_lo_q     <= '0;
      base_q        <= '0;
      data_seen_q   <= 1'b0;
      terminated_q  <= 1'b0;
      halted_q      <= 1'b0;
    end else begin
      phase_q       <= phase_d;
      record_kind_q <= record_kind_d;
      remaining_q   <= remaining_d;
      index_q       <= index_d;
      addr_lo_q     <= addr_lo_d;
      base_q        <= base_d;
      data_seen_q   <= data_seen_d;
      terminated_q  <= terminated_d;
      halted_q      <= halted_d;
    end
  end

  a_quiet_when_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (terminated_q || halted_q) |-> !push_o)
    else $error("result produced after stream was done");

  a_start_terminates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && result_o.kind == lrsp_pkg::KindStart) |=> terminated_q)
    else $error("start address did not terminate the stream");

  a_error_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && (result_o.kind == lrsp_pkg::KindBadLen ||
                result_o.kind == lrsp_pkg::KindEof)) |=> halted_q)
    else $error("error result did not halt the parser");

endmodule

// File: rtl/lrsp_fifo.sv
module lrsp_fifo #(
  parameter int unsigned Depth = lrsp_pkg::FifoDepthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  lrsp_pkg::result_t wdata_i,
  input  logic              pop_i,
  output lrsp_pkg::result_t rdata_o,
  output logic              empty_o,
  output logic              full_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  lrsp_pkg::result_t mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d;
  logic [PtrW-1:0] rptr_q, rptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == FullCnt);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (do_push) begin
      wptr_d = (wptr_q == LastPtr) ? '0 : wptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == LastPtr) ? '0 : rptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i)
    else $error("pop from empty queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt)
    else $error("queue count out of range");

endmodule

// File: rtl/lrsp_back.sv
module lrsp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  lrsp_pkg::result_t head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output lrsp_pkg::result_t out_o
);

  logic              valid_q, valid_d;
  lrsp_pkg::result_t data_q;

  assign pop_o       = !empty_i && (!valid_q || out_ready_i);
  assign valid_d     = pop_o || (valid_q && !out_ready_i);
  assign out_valid_o = valid_q;
  assign out_o       = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q <= head_i;
    end
  end

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !out_ready_i) |=> (valid_q && $stable(data_q)))
    else $error("output beat changed while stalled");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !out_ready_i) |-> !pop_o)
    else $error("queue popped while output stalled");

  a_refill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_i && !valid_q) |=> valid_q)
    else $error("output register not refilled");

endmodule

// File: rtl/load_record_stream_parser.sv
// a result is registered in the queue memory and then in the output register before it is presented
// throughput: one byte per cycle while the queue is not full; the parser state machine advances once per beat
// a queue of FifoDepth entries (two by default) and an output register decouple input from output stalls
// input stalls only when the queue is full behind a stalled output
// reset: asynchronous active low, parser returns to expecting a record type
module load_record_stream_parser #(
  parameter int unsigned FifoDepth = lrsp_pkg::FifoDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  byte_value_i,
  input  logic        end_of_stream_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  kind_o,
  output logic [16:0] address_o,
  output logic [7:0]  value_o,
  output logic        last_o
);

  logic              fire;
  logic              push;
  logic              pop;
  logic              empty;
  logic              full;
  lrsp_pkg::result_t front_res;
  lrsp_pkg::result_t head;
  lrsp_pkg::result_t out_res;

  assign in_ready_o = !full;
  assign fire       = in_valid_i && in_ready_o;

  lrsp_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .fire_i          (fire),
    .byte_value_i    (byte_value_i),
    .end_of_stream_i (end_of_stream_i),
    .push_o          (push),
    .result_o        (front_res)
  );

  lrsp_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (front_res),
    .pop_i   (pop),
    .rdata_o (head),
    .empty_o (empty),
    .full_o  (full)
  );

  lrsp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_res)
  );

  assign kind_o    = out_res.kind;
  assign address_o = out_res.address;
  assign value_o   = out_res.value;
  assign last_o    = out_res.last;

endmodule
